// File: hw/rtl/aesrf_pkg.sv
// Shared types, op codes, S-box table and GF(2^8) helpers for the AES round datapath.
`default_nettype none

package aesrf_pkg;

  localparam int unsigned STATE_COLUMNS = 4;
  localparam int unsigned STATE_BYTES   = 4 * STATE_COLUMNS;
  localparam int unsigned STATE_BITS    = 8 * STATE_BYTES;

  localparam logic [7:0] AES_POLY_LOW = 8'h1b;

  localparam logic [1:0] OP_ADD_KEY   = 2'd0;
  localparam logic [1:0] OP_SUB_SHIFT = 2'd1;
  localparam logic [1:0] OP_FULL      = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] state_hi;
    logic [63:0] state_lo;
    logic [63:0] key_hi;
    logic [63:0] key_lo;
  } rf_in_t;

  typedef struct packed {
    logic [63:0] out_hi;
    logic [63:0] out_lo;
  } rf_out_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  // Multiplication by two in GF(2^8), reduced by the AES polynomial.
  function automatic logic [7:0] xtime(input logic [7:0] v);
    xtime = {v[6:0], 1'b0} ^ (v[7] ? AES_POLY_LOW : 8'h00);
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/aes_round_function.sv
// Four-stage pipelined AES round: capture, SubBytes+ShiftRows, MixColumns, key add and select.
// An item is taken in every cycle; busy is never raised since results cannot be held off.
// The result strobe is the valid bit carried through the stage 1, 2 and 3 registers into the output register.
// Throughput: one item per clock cycle, set by the single-pass stage datapath.
// Reset clears only the stage valid bits; payload registers are not reset.
`default_nettype none

module aes_round_function
  import aesrf_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  rf_in_t  req_i,
  output logic    busy,
  output logic    result_valid_o,
  output rf_out_t result_o
);

  // Stage 1: captured item.
  logic                  s1_valid_q;
  logic [1:0]            s1_op_q;
  logic [STATE_BITS-1:0] s1_state_q, s1_key_q;

  // Stage 2: after SubBytes and ShiftRows.
  logic                  s2_valid_q;
  logic [1:0]            s2_op_q;
  logic [STATE_BITS-1:0] s2_state_q, s2_key_q, s2_ss_q;
  logic [STATE_BITS-1:0] s2_ss_d;

  // Stage 3: after MixColumns.
  logic                  s3_valid_q;
  logic [1:0]            s3_op_q;
  logic [STATE_BITS-1:0] s3_state_q, s3_key_q, s3_ss_q, s3_mix_q;
  logic [STATE_BITS-1:0] s3_mix_d;

  // Stage 4: output register.
  logic                  out_valid_q;
  logic [STATE_BITS-1:0] out_q, out_d;

  assign busy = 1'b0;

  always_comb begin
    logic [7:0] src;
    s2_ss_d = '0;
    for (int c = 0; c < STATE_COLUMNS; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = s1_state_q[STATE_BITS-1-8*(r+4*((c+r) % STATE_COLUMNS)) -: 8];
        s2_ss_d[STATE_BITS-1-8*(r+4*c) -: 8] = SBOX[src];
      end
    end
  end

  aesrf_mix_columns u_mix (
    .state_i (s2_ss_q),
    .state_o (s3_mix_d)
  );

  always_comb begin
    case (s3_op_q)
      OP_ADD_KEY:   out_d = s3_state_q ^ s3_key_q;
      OP_SUB_SHIFT: out_d = s3_ss_q;
      OP_FULL:      out_d = s3_mix_q ^ s3_key_q;
      // The unused op code passes the state through untouched.
      default:      out_d = s3_state_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= start && !busy;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      s1_op_q    <= req_i.op;
      s1_state_q <= {req_i.state_hi, req_i.state_lo};
      s1_key_q   <= {req_i.key_hi, req_i.key_lo};
    end
    if (s1_valid_q) begin
      s2_op_q    <= s1_op_q;
      s2_state_q <= s1_state_q;
      s2_key_q   <= s1_key_q;
      s2_ss_q    <= s2_ss_d;
    end
    if (s2_valid_q) begin
      s3_op_q    <= s2_op_q;
      s3_state_q <= s2_state_q;
      s3_key_q   <= s2_key_q;
      s3_ss_q    <= s2_ss_q;
      s3_mix_q   <= s3_mix_d;
    end
    if (s3_valid_q) begin
      out_q <= out_d;
    end
  end

  assign result_valid_o  = out_valid_q;
  assign result_o.out_hi = out_q[STATE_BITS-1 -: 64];
  assign result_o.out_lo = out_q[63:0];

endmodule

`default_nettype wire

// File: hw/rtl/aesrf_mix_columns.sv
// MixColumns over the four state columns, purely combinational.
`default_nettype none

module aesrf_mix_columns
  import aesrf_pkg::*;
(
  input  logic [STATE_BITS-1:0] state_i,
  output logic [STATE_BITS-1:0] state_o
);

  always_comb begin
    logic [7:0] a0, a1, a2, a3;
    state_o = '0;
    for (int c = 0; c < STATE_COLUMNS; c++) begin
      for (int r = 0; r < 4; r++) begin
        a0 = state_i[STATE_BITS-1-8*(4*c+r)           -: 8];
        a1 = state_i[STATE_BITS-1-8*(4*c+((r+1) % 4)) -: 8];
        a2 = state_i[STATE_BITS-1-8*(4*c+((r+2) % 4)) -: 8];
        a3 = state_i[STATE_BITS-1-8*(4*c+((r+3) % 4)) -: 8];
        state_o[STATE_BITS-1-8*(4*c+r) -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      end
    end
  end

endmodule

`default_nettype wire
